/* hw/rtl/fsc_pkg.sv */
// Shared types, constants and helpers for the frustum sphere culler.
// No dependencies; the square root, divider, culler and testbench refer to it by scoped names.
`default_nettype none
package fsc_pkg;

  localparam int DATA_W      = 32;
  localparam int COORD_W     = 32;
  localparam int PLANE_W     = 48;
  localparam int NUM_W       = 62;
  localparam int MUL_W       = 34;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int MAT_DEPTH   = 16;
  localparam int PLANE_DEPTH = 24;
  localparam int MAT_AW      = $clog2(MAT_DEPTH);
  localparam int PLANE_AW    = $clog2(PLANE_DEPTH);

  localparam logic [1:0] COMP_OFFSET = 2'd3;
  localparam logic [1:0] ROW_W       = 2'd3;
  localparam logic [2:0] LAST_PLANE  = 3'd5;
  localparam logic [2:0] LAST_MAT_RD = 3'd7;

  typedef enum logic [1:0] {
    CFG_VIEWER_X = 2'd0,
    CFG_VIEWER_Y = 2'd1,
    CFG_VIEWER_Z = 2'd2,
    CFG_MAX_DIST = 2'd3
  } fsc_cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPH_RD,
    ST_SPH_DX,
    ST_SPH_DY,
    ST_SPH_DZ,
    ST_SPH_DL,
    ST_SPH_DW,
    ST_SPH_CMP,
    ST_EX_RD,
    ST_EX_WT,
    ST_EX_SQ,
    ST_EX_SQS,
    ST_EX_SQRT,
    ST_EX_COMP,
    ST_EX_DIVW
  } fsc_state_t;

  typedef enum logic [2:0] {
    PT_NONE,
    PT_PLANE,
    PT_DX,
    PT_DY,
    PT_DZ,
    PT_LIM,
    PT_LEN
  } fsc_ptag_t;

  typedef struct packed {
    logic                 start;
    logic [NUM_W-1:0]     num;
    logic [DATA_W-1:0]    den;
  } fsc_div_req_t;

  // saturate a 33-bit signed sum to 32 bits
  function automatic logic [DATA_W-1:0] fsc_sat33(input logic [DATA_W:0] s);
    logic [DATA_W-1:0] res;
    if (s[DATA_W] != s[DATA_W-1]) begin
      res = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      res = s[DATA_W-1:0];
    end
    return res;
  endfunction

  // apply sign to a magnitude and saturate to 32 bits
  function automatic logic [DATA_W-1:0] fsc_sat_mag(input logic neg,
                                                   input logic [NUM_W-1:0] mag);
    logic [DATA_W-1:0] res;
    logic              big;
    if (neg) begin
      big = (|mag[NUM_W-1:DATA_W]) || (mag[DATA_W-1] && (|mag[DATA_W-2:0]));
      res = big ? {1'b1, {(DATA_W-1){1'b0}}} : (~mag[DATA_W-1:0] + {{(DATA_W-1){1'b0}}, 1'b1});
    end else begin
      big = |mag[NUM_W-1:DATA_W-1];
      res = big ? {1'b0, {(DATA_W-1){1'b1}}} : mag[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/fsc_isqrt.sv */
// Iterative integer square root, two result bits per step pair, 32 steps.
// Depends on fsc_pkg.
`default_nettype none
module fsc_isqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [2*fsc_pkg::DATA_W-1:0] val,
  output logic                             done,
  output logic [fsc_pkg::DATA_W-1:0]       root
);

  localparam int VW = 2 * fsc_pkg::DATA_W;

  logic [VW-1:0] v_r, r_r, b_r;
  logic [5:0]    cnt_r;
  logic          busy_r, done_r;
  logic [VW:0]   rb;
  logic          ge;

  assign rb   = {1'b0, r_r} + {1'b0, b_r};
  assign ge   = {1'b0, v_r} >= rb;
  assign done = done_r;
  assign root = r_r[fsc_pkg::DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(fsc_pkg::DATA_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r <= val;
      r_r <= '0;
      b_r <= {2'b01, {(VW-2){1'b0}}};
    end else if (busy_r) begin
      if (ge) begin
        v_r <= v_r - rb[VW-1:0];
        r_r <= (r_r >> 1) + b_r;
      end else begin
        r_r <= r_r >> 1;
      end
      b_r <= b_r >> 2;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/fsc_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on fsc_pkg.
`default_nettype none
module fsc_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire fsc_pkg::fsc_div_req_t      req,
  output logic                            done,
  output logic [fsc_pkg::NUM_W-1:0]       quot
);

  localparam int NW = fsc_pkg::NUM_W;
  localparam int DW = fsc_pkg::DATA_W;

  logic [DW-1:0] rem_r, den_r;
  logic [NW-1:0] num_r, quot_r;
  logic [5:0]    cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   trial, diff;
  logic          ge;

  assign trial = {rem_r, num_r[NW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};
  assign done  = done_r;
  assign quot  = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(NW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= '0;
      den_r  <= req.den;
      num_r  <= req.num;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      num_r  <= {num_r[NW-2:0], 1'b0};
      quot_r <= {quot_r[NW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/frustum_sphere_culler.sv */
// Frustum sphere culler: matrix element words load a 4x4 store; the word flagged last
// extracts six normalized planes into the plane store. A sphere word reads the six planes
// one entry a cycle through the shared multiplier, then runs the draw-distance test on the
// same multiplier and gives its result once the output slot is free. A matrix word without
// tlast leaves the input ready for the next word. A word with tlast holds off the input
// while the one-bit-per-cycle divider (four 62-step divisions for each plane) and the
// 32-step square root run.
// Depends on fsc_pkg, fsc_isqrt and fsc_div.
`default_nettype none
module frustum_sphere_culler (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // mat_col[1:0], mat_row[3:2], mat_value[35:4], sphere_x[67:36], sphere_y[99:68],
  // sphere_z[131:100], sphere_radius[162:132], zero fill[167:163]
  input  wire logic [167:0] in_tdata,
  input  wire logic         in_tlast,
  // func[0]
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // inside_frustum[0], beyond_distance[1], visible[2], zero fill[7:3]
  output logic [7:0]        out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata
);

  localparam int DW  = fsc_pkg::DATA_W;
  localparam int MW  = fsc_pkg::MUL_W;
  localparam int PW  = fsc_pkg::PROD_W;
  localparam int PLW = fsc_pkg::PLANE_W;

  fsc_pkg::fsc_state_t state_r, state_nxt;

  logic [DW-1:0] vx_r, vy_r, vz_r, md_r;
  logic [DW-1:0] sx_r, sy_r, sz_r;
  logic [30:0]   rad_r;

  logic [DW-1:0]  mat_mem [fsc_pkg::MAT_DEPTH];
  logic [DW-1:0]  mat_rdata_r;
  logic [PLW-1:0] plane_mem [fsc_pkg::PLANE_DEPTH];
  logic [PLW-1:0] pl_rdata_r;
  logic           planes_valid_r;

  logic [fsc_pkg::PLANE_AW-1:0] k_r, s1_k_r, s2_k_r;
  logic                         s1_v_r, s2_v_r;
  logic [DW-1:0]                s2_off_r;
  logic signed [65:0]           acc_r;
  logic                         inside_r;
  logic [63:0]                  dsum_r, lim2_r, len2_r;

  logic [2:0]    pi_r, j_r, e1_j_r;
  logic          e1_v_r;
  logic [1:0]    c_r;
  logic [DW-1:0] a_r;
  logic [DW-1:0] raw_r [4];

  logic signed [PW-1:0] prod_r;
  fsc_pkg::fsc_ptag_t   ptag_r;
  logic signed [MW-1:0] mul_a, mul_b;
  fsc_pkg::fsc_ptag_t   mul_tag;

  logic                              in_acc, mat_we;
  logic [fsc_pkg::MAT_AW-1:0]        mat_raddr;
  logic                              pl_we;
  logic [fsc_pkg::PLANE_AW-1:0]      pl_waddr;
  logic [PLW-1:0]                    pl_wdata;
  logic                              sq_start, sq_done;
  logic [DW-1:0]                     sq_root;
  fsc_pkg::fsc_div_req_t             dv_req;
  logic                              dv_done;
  logic [fsc_pkg::NUM_W-1:0]         dv_quot;
  logic                              len_zero, plane_end, extr_end, slot_free;

  logic [DW-1:0]   pl_q, raw_c, raw_mag, w_val;
  logic [DW:0]     dx, dy, dz, lim;
  logic            md_pos, beyond;
  logic [64:0]     dsum_add;
  logic [DW:0]     raw_sum;
  logic [37:0]     pd_sum;

  assign in_acc    = in_tvalid & in_tready;
  assign mat_we    = in_acc & ~in_tuser;
  assign in_tready = (state_r == fsc_pkg::ST_IDLE);
  assign len_zero  = (sq_root == '0);
  assign plane_end = (c_r == fsc_pkg::COMP_OFFSET);
  assign extr_end  = plane_end && (pi_r == fsc_pkg::LAST_PLANE);
  assign slot_free = ~out_tvalid | out_tready;
  assign pl_q      = planes_valid_r ? pl_rdata_r[DW-1:0] : '0;
  assign raw_c     = raw_r[c_r];
  assign raw_mag   = raw_c[DW-1] ? (~raw_c + {{(DW-1){1'b0}}, 1'b1}) : raw_c;
  assign dx        = {sx_r[DW-1], sx_r} - {vx_r[DW-1], vx_r};
  assign dy        = {sy_r[DW-1], sy_r} - {vy_r[DW-1], vy_r};
  assign dz        = {sz_r[DW-1], sz_r} - {vz_r[DW-1], vz_r};
  assign lim       = {1'b0, md_r} + {2'b00, rad_r};
  assign md_pos    = ~md_r[DW-1] && (md_r != '0);
  assign beyond    = md_pos && (dsum_r > lim2_r);
  assign dsum_add  = {1'b0, dsum_r} + {1'b0, prod_r[63:0]};
  assign pd_sum    = {{2{acc_r[65]}}, acc_r[65:30]} + {{6{s2_off_r[DW-1]}}, s2_off_r}
                   + {7'd0, rad_r};
  assign raw_sum   = pi_r[0] ? ({a_r[DW-1], a_r} - {mat_rdata_r[DW-1], mat_rdata_r})
                             : ({a_r[DW-1], a_r} + {mat_rdata_r[DW-1], mat_rdata_r});

  fsc_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .val   (len2_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  fsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dv_req),
    .done  (dv_done),
    .quot  (dv_quot)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fsc_pkg::ST_IDLE: begin
        if (in_acc && in_tuser) begin
          state_nxt = fsc_pkg::ST_SPH_RD;
        end else if (in_acc && in_tlast) begin
          state_nxt = fsc_pkg::ST_EX_RD;
        end
      end
      fsc_pkg::ST_SPH_RD: begin
        if (k_r == fsc_pkg::PLANE_AW'(fsc_pkg::PLANE_DEPTH - 1)) state_nxt = fsc_pkg::ST_SPH_DX;
      end
      fsc_pkg::ST_SPH_DX:  state_nxt = fsc_pkg::ST_SPH_DY;
      fsc_pkg::ST_SPH_DY:  state_nxt = fsc_pkg::ST_SPH_DZ;
      fsc_pkg::ST_SPH_DZ:  state_nxt = fsc_pkg::ST_SPH_DL;
      fsc_pkg::ST_SPH_DL:  state_nxt = fsc_pkg::ST_SPH_DW;
      fsc_pkg::ST_SPH_DW:  state_nxt = fsc_pkg::ST_SPH_CMP;
      fsc_pkg::ST_SPH_CMP: begin
        if (slot_free) state_nxt = fsc_pkg::ST_IDLE;
      end
      fsc_pkg::ST_EX_RD: begin
        if (j_r == fsc_pkg::LAST_MAT_RD) state_nxt = fsc_pkg::ST_EX_WT;
      end
      fsc_pkg::ST_EX_WT:  state_nxt = fsc_pkg::ST_EX_SQ;
      fsc_pkg::ST_EX_SQ: begin
        if (c_r == fsc_pkg::COMP_OFFSET) state_nxt = fsc_pkg::ST_EX_SQS;
      end
      fsc_pkg::ST_EX_SQS: state_nxt = fsc_pkg::ST_EX_SQRT;
      fsc_pkg::ST_EX_SQRT: begin
        if (sq_done) state_nxt = fsc_pkg::ST_EX_COMP;
      end
      fsc_pkg::ST_EX_COMP: begin
        if (!len_zero) begin
          state_nxt = fsc_pkg::ST_EX_DIVW;
        end else if (extr_end) begin
          state_nxt = fsc_pkg::ST_IDLE;
        end else if (plane_end) begin
          state_nxt = fsc_pkg::ST_EX_RD;
        end
      end
      fsc_pkg::ST_EX_DIVW: begin
        if (dv_done) begin
          if (extr_end) begin
            state_nxt = fsc_pkg::ST_IDLE;
          end else if (plane_end) begin
            state_nxt = fsc_pkg::ST_EX_RD;
          end else begin
            state_nxt = fsc_pkg::ST_EX_COMP;
          end
        end
      end
      default: state_nxt = fsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mat_raddr  = j_r[0] ? {pi_r[2:1], j_r[2:1]} : {fsc_pkg::ROW_W, j_r[2:1]};
    pl_waddr   = {pi_r, c_r};
    w_val      = (c_r == fsc_pkg::COMP_OFFSET) ? raw_c : '0;
    pl_we      = 1'b0;
    sq_start   = (state_r == fsc_pkg::ST_EX_SQS);
    dv_req.start = 1'b0;
    dv_req.den   = sq_root;
    dv_req.num   = (c_r == fsc_pkg::COMP_OFFSET) ? {14'd0, raw_mag, 16'd0} : {raw_mag, 30'd0};
    if (state_r == fsc_pkg::ST_EX_COMP) begin
      pl_we        = len_zero;
      dv_req.start = ~len_zero;
    end else if (state_r == fsc_pkg::ST_EX_DIVW) begin
      pl_we = dv_done;
      w_val = fsc_pkg::fsc_sat_mag(raw_c[DW-1], dv_quot);
    end
    pl_wdata = {{(PLW-DW){w_val[DW-1]}}, w_val};

    mul_a   = '0;
    mul_b   = '0;
    mul_tag = fsc_pkg::PT_NONE;
    priority if (s1_v_r && (s1_k_r[1:0] != fsc_pkg::COMP_OFFSET)) begin
      mul_a   = {{(MW-DW){pl_q[DW-1]}}, pl_q};
      mul_tag = fsc_pkg::PT_PLANE;
      unique case (s1_k_r[1:0])
        2'd0:    mul_b = {{(MW-DW){sx_r[DW-1]}}, sx_r};
        2'd1:    mul_b = {{(MW-DW){sy_r[DW-1]}}, sy_r};
        default: mul_b = {{(MW-DW){sz_r[DW-1]}}, sz_r};
      endcase
    end else if (state_r == fsc_pkg::ST_SPH_DX) begin
      mul_a   = {dx[DW], dx};
      mul_b   = {dx[DW], dx};
      mul_tag = fsc_pkg::PT_DX;
    end else if (state_r == fsc_pkg::ST_SPH_DY) begin
      mul_a   = {dy[DW], dy};
      mul_b   = {dy[DW], dy};
      mul_tag = fsc_pkg::PT_DY;
    end else if (state_r == fsc_pkg::ST_SPH_DZ) begin
      mul_a   = {dz[DW], dz};
      mul_b   = {dz[DW], dz};
      mul_tag = fsc_pkg::PT_DZ;
    end else if (state_r == fsc_pkg::ST_SPH_DL) begin
      mul_a   = {1'b0, lim};
      mul_b   = {1'b0, lim};
      mul_tag = fsc_pkg::PT_LIM;
    end else if ((state_r == fsc_pkg::ST_EX_SQ) && (c_r != fsc_pkg::COMP_OFFSET)) begin
      mul_a   = {{(MW-DW){raw_c[DW-1]}}, raw_c};
      mul_b   = {{(MW-DW){raw_c[DW-1]}}, raw_c};
      mul_tag = fsc_pkg::PT_LEN;
    end else begin
      mul_tag = fsc_pkg::PT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (mat_we) mat_mem[{in_tdata[3:2], in_tdata[1:0]}] <= in_tdata[35:4];
    mat_rdata_r <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk) begin
    if (pl_we) plane_mem[pl_waddr] <= pl_wdata;
    if (state_r == fsc_pkg::ST_SPH_RD) pl_rdata_r <= plane_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= fsc_pkg::ST_IDLE;
      vx_r           <= '0;
      vy_r           <= '0;
      vz_r           <= '0;
      md_r           <= '0;
      planes_valid_r <= 1'b0;
      out_tvalid     <= 1'b0;
      s1_v_r         <= 1'b0;
      s2_v_r         <= 1'b0;
      e1_v_r         <= 1'b0;
      ptag_r         <= fsc_pkg::PT_NONE;
      k_r            <= '0;
      pi_r           <= '0;
      j_r            <= '0;
      c_r            <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (fsc_pkg::fsc_cfg_idx_t'(cfg_addr))
          fsc_pkg::CFG_VIEWER_X: vx_r <= cfg_wdata;
          fsc_pkg::CFG_VIEWER_Y: vy_r <= cfg_wdata;
          fsc_pkg::CFG_VIEWER_Z: vz_r <= cfg_wdata;
          default:               md_r <= cfg_wdata;
        endcase
      end
      if (pl_we) planes_valid_r <= 1'b1;
      s1_v_r <= (state_r == fsc_pkg::ST_SPH_RD);
      s2_v_r <= s1_v_r;
      e1_v_r <= (state_r == fsc_pkg::ST_EX_RD);
      ptag_r <= mul_tag;
      if ((state_r == fsc_pkg::ST_SPH_CMP) && slot_free) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end

      unique case (state_r)
        fsc_pkg::ST_IDLE: begin
          k_r  <= '0;
          pi_r <= '0;
          j_r  <= '0;
        end
        fsc_pkg::ST_SPH_RD: k_r <= k_r + 1'b1;
        fsc_pkg::ST_EX_RD:  j_r <= j_r + 3'd1;
        fsc_pkg::ST_EX_WT:  c_r <= '0;
        fsc_pkg::ST_EX_SQ:  c_r <= c_r + 2'd1;
        fsc_pkg::ST_EX_COMP: begin
          if (len_zero) begin
            c_r <= c_r + 2'd1;
            if (plane_end) pi_r <= pi_r + 3'd1;
          end
        end
        fsc_pkg::ST_EX_DIVW: begin
          if (dv_done) begin
            c_r <= c_r + 2'd1;
            if (plane_end) pi_r <= pi_r + 3'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= mul_a * mul_b;
    s1_k_r   <= k_r;
    s2_k_r   <= s1_k_r;
    s2_off_r <= pl_q;
    e1_j_r   <= j_r;

    if (in_acc && in_tuser) begin
      sx_r     <= in_tdata[67:36];
      sy_r     <= in_tdata[99:68];
      sz_r     <= in_tdata[131:100];
      rad_r    <= in_tdata[162:132];
      inside_r <= 1'b1;
    end else if (s2_v_r) begin
      if (s2_k_r[1:0] == fsc_pkg::COMP_OFFSET) begin
        if (pd_sum[37]) inside_r <= 1'b0;
      end else if (s2_k_r[1:0] == 2'd0) begin
        acc_r <= prod_r[65:0];
      end else begin
        acc_r <= acc_r + prod_r[65:0];
      end
    end

    if (state_r == fsc_pkg::ST_EX_RD) begin
      len2_r <= '0;
    end else if (ptag_r == fsc_pkg::PT_LEN) begin
      len2_r <= len2_r + prod_r[63:0];
    end
    if (ptag_r == fsc_pkg::PT_DX) dsum_r <= prod_r[63:0];
    if ((ptag_r == fsc_pkg::PT_DY) || (ptag_r == fsc_pkg::PT_DZ)) begin
      dsum_r <= dsum_add[64] ? '1 : dsum_add[63:0];
    end
    if (ptag_r == fsc_pkg::PT_LIM) lim2_r <= prod_r[63:0];

    if (e1_v_r) begin
      if (!e1_j_r[0]) begin
        a_r <= mat_rdata_r;
      end else begin
        raw_r[e1_j_r[2:1]] <= fsc_pkg::fsc_sat33(raw_sum);
      end
    end

    if ((state_r == fsc_pkg::ST_SPH_CMP) && slot_free) begin
      out_tdata <= {5'd0, inside_r & ~beyond, beyond, inside_r};
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/fsc_checker.sv */
// Port-level checks for the frustum sphere culler, bound to the top level.
// Depends on frustum_sphere_culler ports only.
`default_nettype none
module fsc_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [167:0] in_tdata,
  input wire logic         in_tlast,
  input wire logic         in_tuser,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [7:0]   out_tdata,
  input wire logic         cfg_we,
  input wire logic [1:0]   cfg_addr,
  input wire logic [31:0]  cfg_wdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_visible: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2] == (out_tdata[0] && !out_tdata[1]))
    else $error("visible flag inconsistent");

  a_sphere_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("sphere word did not occupy the block");

  a_elem_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !in_tlast |=> in_tready)
    else $error("plain matrix word stalled input");

endmodule

bind frustum_sphere_culler fsc_checker u_fsc_checker (.*);
`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for frustum_sphere_culler: loads matrices, tests spheres and
// compares each result word against a bit-exact plane/distance predictor kept here.
// Depends on fsc_pkg for the register index names.
`default_nettype none
module tb;

  localparam logic FUNC_MAT    = 1'b0;
  localparam logic FUNC_SPHERE = 1'b1;
  localparam int   CYCLE_LIMIT = 2000000;
  localparam int   EXTRACT_WAIT = 2500;
  localparam int   RANDOM_ITEMS = 1850;

  typedef struct packed {
    logic in_frustum;
    logic beyond;
    logic visible;
  } cull_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [167:0] in_tdata;
  logic         in_tlast;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [7:0]   out_tdata;
  logic         cfg_we;
  logic [1:0]   cfg_addr;
  logic [31:0]  cfg_wdata;

  frustum_sphere_culler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  longint     mat_q[16];
  longint     plane_q[24];
  longint     viewer_x_q, viewer_y_q, viewer_z_q, max_dist_q;
  logic [15:0] mat_written;
  cull_t      cull_expected[$];
  int         mismatches = 0;
  int         items_sent;
  int         burst_left;
  bit         no_idle;
  int         cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("frustum_sphere_culler regression: fail");
      $finish;
    end
  end

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void extract_planes();
    longint          raw[4];
    longint unsigned len2, len;
    longint          a, b;
    for (int i = 0; i < 6; i++) begin
      len2 = 0;
      for (int c = 0; c < 4; c++) begin
        a = mat_q[12 + c];
        b = mat_q[(i / 2) * 4 + c];
        raw[c] = sat32((i % 2 == 1) ? a - b : a + b);
      end
      for (int c = 0; c < 3; c++) len2 += longint'(raw[c] * raw[c]);
      len = isqrt(len2);
      if (len == 0) begin
        for (int c = 0; c < 3; c++) plane_q[i * 4 + c] = 0;
        plane_q[i * 4 + 3] = raw[3];
      end else begin
        for (int c = 0; c < 3; c++)
          plane_q[i * 4 + c] = sat32((raw[c] * (64'sd1 << 30)) / longint'(len));
        plane_q[i * 4 + 3] = sat32((raw[3] * (64'sd1 << 16)) / longint'(len));
      end
    end
  endfunction

  function automatic longint unsigned sq_diff(input longint p, input longint v);
    longint          d;
    longint unsigned m;
    d = p - v;
    m = (d < 0) ? -d : d;
    return m * m;
  endfunction

  function automatic longint unsigned add_sat(input longint unsigned a,
                                              input longint unsigned b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  function automatic cull_t cull_sphere(input longint x, input longint y,
                                        input longint z, input longint r);
    cull_t           res;
    longint          acc, d;
    longint unsigned s, lim;
    res.in_frustum = 1'b1;
    res.beyond = 1'b0;
    for (int i = 0; i < 6; i++) begin
      acc = plane_q[i*4] * x + plane_q[i*4+1] * y + plane_q[i*4+2] * z;
      d = sat32((acc >>> 30) + plane_q[i*4+3]);
      if (d < -r) begin
        res.in_frustum = 1'b0;
        break;
      end
    end
    if (max_dist_q > 0) begin
      s = add_sat(add_sat(sq_diff(x, viewer_x_q), sq_diff(y, viewer_y_q)),
                  sq_diff(z, viewer_z_q));
      lim = max_dist_q + r;
      res.beyond = s > lim * lim;
    end
    res.visible = res.in_frustum && !res.beyond;
    return res;
  endfunction

  // drive one word, wait for acceptance, update the predictor
  task automatic send_word(input logic func, input logic [1:0] row, input logic [1:0] col,
                           input logic [31:0] val, input logic last, input logic [31:0] x,
                           input logic [31:0] y, input logic [31:0] z,
                           input logic [30:0] r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tuser  = func;
    in_tlast  = last;
    in_tdata  = {5'b0, r, z, y, x, val, row, col};
    in_tvalid = 1'b1;
    #4;
    while (!in_tready) begin
      @(negedge clk);
      #4;
    end
    @(negedge clk);
    items_sent++;
    if (func == FUNC_MAT) begin
      mat_q[row * 4 + col] = longint'(signed'(val));
      mat_written[row * 4 + col] = 1'b1;
      if (last) extract_planes();
    end else begin
      cull_expected.push_back(cull_sphere(longint'(signed'(x)), longint'(signed'(y)),
                                          longint'(signed'(z)), longint'(r)));
    end
  endtask

  task automatic send_mat(input int row, input int col, input logic [31:0] val,
                          input logic last);
    send_word(FUNC_MAT, row[1:0], col[1:0], val, last, $urandom, $urandom, $urandom,
              31'($urandom));
  endtask

  task automatic send_sphere(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [30:0] r);
    send_word(FUNC_SPHERE, 2'($urandom), 2'($urandom), $urandom, 1'($urandom), x, y, z, r);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (cull_expected.size() != 0) @(negedge clk);
    repeat (EXTRACT_WAIT) @(negedge clk);
  endtask

  task automatic cfg_write(input fsc_pkg::fsc_cfg_idx_t idx, input logic [31:0] val);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      fsc_pkg::CFG_VIEWER_X: viewer_x_q = longint'(signed'(val));
      fsc_pkg::CFG_VIEWER_Y: viewer_y_q = longint'(signed'(val));
      fsc_pkg::CFG_VIEWER_Z: viewer_z_q = longint'(signed'(val));
      fsc_pkg::CFG_MAX_DIST: max_dist_q = longint'(signed'(val));
      default: ;
    endcase
  endtask

  task automatic set_view(input logic [31:0] vx, input logic [31:0] vy,
                          input logic [31:0] vz, input logic [31:0] md);
    cfg_write(fsc_pkg::CFG_VIEWER_X, vx);
    cfg_write(fsc_pkg::CFG_VIEWER_Y, vy);
    cfg_write(fsc_pkg::CFG_VIEWER_Z, vz);
    cfg_write(fsc_pkg::CFG_MAX_DIST, md);
  endtask

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'h0;
      default: return $urandom_range(0, 32'h4_0000) - 32'h2_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 32'h10_0000) - 32'h8_0000;
    endcase
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 9))
      0: return 31'($urandom);
      1: return $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0;
      default: return 31'($urandom_range(0, 32'h4_0000));
    endcase
  endfunction

  // all sixteen elements in random order, last flag on the final one
  task automatic load_matrix(input logic [31:0] vals[16]);
    int order[16];
    int j, t;
    for (int i = 0; i < 16; i++) order[i] = i;
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < 16; i++)
      send_mat(order[i] / 4, order[i] % 4, vals[order[i]], i == 15);
  endtask

  task automatic test_planes_at_reset();
    send_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 31'h0);
    send_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
  endtask

  task automatic test_directed();
    logic [31:0] m[16];
    for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'h1_0000 : 32'h0;
    load_matrix(m);
    send_sphere(32'h0, 32'h0, 32'h0, 31'h0);
    send_sphere(32'h3_0000, 32'h0, 32'h0, 31'h1_0000);
    send_sphere(32'h3_0000, 32'h0, 32'h0, 31'h2_0000);
    send_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
    // zero normal length on every plane: leaves planes unscaled
    for (int i = 0; i < 16; i++) m[i] = (i == 15) ? 32'hFFFF_0000 : 32'h0;
    load_matrix(m);
    send_sphere(32'h1234, 32'h0, 32'h0, 31'h0);
    send_sphere(32'h1234, 32'h0, 32'h0, 31'h1_0000);
    // saturating rows
    for (int i = 0; i < 16; i++) m[i] = i[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
    load_matrix(m);
    send_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0);
    send_sphere(32'h8000_0000, 32'h1, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    drain();
  endtask

  task automatic test_random(input int count);
    logic [31:0] m[16];
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 99))
        0, 1, 2, 3, 4, 5: begin
          for (int i = 0; i < 16; i++) m[i] = rand_elem();
          load_matrix(m);
        end
        6, 7, 8: send_mat($urandom_range(0, 3), $urandom_range(0, 3), rand_elem(),
                          (&mat_written) ? 1'($urandom) : 1'b0);
        9: begin
          no_idle = !no_idle;
          burst_left = 0;
        end
        default: send_sphere(rand_coord(), rand_coord(), rand_coord(), rand_radius());
      endcase
    end
    drain();
  endtask

  task automatic test_full_drain();
    for (int i = 0; i < 6; i++)
      send_sphere(rand_coord(), rand_coord(), rand_coord(), rand_radius());
    drain();
    for (int i = 0; i < 6; i++)
      send_sphere(rand_coord(), rand_coord(), rand_coord(), rand_radius());
    drain();
  endtask

  // receiver: stall pattern switches among four random modes; each result word is checked
  initial begin
    int mode;
    cull_t got, want;
    mode = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (cycle_count % 200 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_tready = 1'b1;
        1: out_tready = $urandom_range(0, 1);
        2: out_tready = ($urandom_range(0, 3) == 0);
        default: out_tready = ((cycle_count / 16) % 2 == 0);
      endcase
      #4;
      if (out_tvalid && out_tready) begin
        got = {out_tdata[0], out_tdata[1], out_tdata[2]};
        if (cull_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %b", out_tdata[2:0]);
        end else begin
          want = cull_expected.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: inside %b/%b beyond %b/%b visible %b/%b (exp/act)",
                       want.in_frustum, got.in_frustum, want.beyond, got.beyond,
                       want.visible, got.visible);
          end
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    in_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = fsc_pkg::CFG_VIEWER_X;
    cfg_wdata = '0;
    items_sent = 0;
    burst_left = 0;
    no_idle = 1'b0;
    mat_written = '0;
    viewer_x_q = 0;
    viewer_y_q = 0;
    viewer_z_q = 0;
    max_dist_q = 0;
    for (int i = 0; i < 16; i++) mat_q[i] = 0;
    for (int i = 0; i < 24; i++) plane_q[i] = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    set_view(32'h0, 32'h0, 32'h0, 32'h4_0000);
    test_planes_at_reset();
    test_directed();
    test_full_drain();
    test_random(RANDOM_ITEMS / 4);
    set_view($urandom_range(0, 32'h8_0000) - 32'h4_0000, $urandom_range(0, 32'h8_0000)
             - 32'h4_0000, $urandom_range(0, 32'h8_0000) - 32'h4_0000, 32'h5_0000);
    test_random(RANDOM_ITEMS / 4);
    set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    test_random(RANDOM_ITEMS / 4);
    set_view($urandom, $urandom, $urandom, 32'h8000_0000);
    test_random(RANDOM_ITEMS / 8);
    set_view(32'h0, 32'h0, 32'h0, 32'h0);
    test_random(RANDOM_ITEMS / 8);

    if ((mismatches == 0) && (cull_expected.size() == 0)) begin
      $display("frustum_sphere_culler regression: pass");
    end else begin
      $display("frustum_sphere_culler regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
hw/rtl/fsc_pkg.sv
hw/rtl/fsc_isqrt.sv
hw/rtl/fsc_div.sv
hw/rtl/frustum_sphere_culler.sv
hw/rtl/fsc_checker.sv
tb/sv/tb.sv
